>>> hdl/lbt_pkg.sv
// ----------------------------------------------------------------------------
// Log bookmark table package
// Shared constants, item kinds and record types of the bookmark table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lbt_pkg;

	localparam int MAX_MARKS = 32;
	localparam int ADDR_W    = $clog2(MAX_MARKS);
	localparam int CNT_W     = $clog2(MAX_MARKS + 1);
	localparam int AREA_W    = 8;
	localparam int WORD_W    = 32;

	localparam logic [WORD_W-1:0] WORD_ONES = '1;

	typedef enum logic [1:0] {
		KIND_ADD    = 2'd0,
		KIND_ROTATE = 2'd1,
		KIND_CLEAR  = 2'd2,
		KIND_QUERY  = 2'd3
	} kind_t;

	// One stored bookmark.
	typedef struct packed {
		logic [AREA_W-1:0] area;
		logic [WORD_W-1:0] offset;
		logic [WORD_W-1:0] index;
	} mark_t;

	// Outputs of the shared compare unit.
	typedef struct packed {
		logic              area_hit;
		logic              take;
		logic [WORD_W-1:0] gap;
	} cmp_res_t;

endpackage

`default_nettype wire

>>> hdl/lbt_mem.sv
// ----------------------------------------------------------------------------
// Bookmark storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbt_mem (
	input  wire                        clk,
	input  wire                        wr_en,
	input  wire  [lbt_pkg::ADDR_W-1:0] wr_addr,
	input  wire  lbt_pkg::mark_t       wr_data,
	input  wire                        rd_en,
	input  wire  [lbt_pkg::ADDR_W-1:0] rd_addr,
	output lbt_pkg::mark_t             rd_data
);
	import lbt_pkg::*;

	mark_t mem_q [MAX_MARKS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> hdl/lbt_cmp.sv
// ----------------------------------------------------------------------------
// Bookmark compare unit
// Distance from key to a stored index, closest-so-far test and area match.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbt_cmp (
	input  wire  [lbt_pkg::WORD_W-1:0] key,
	input  wire  [lbt_pkg::WORD_W-1:0] idx,
	input  wire  [lbt_pkg::WORD_W-1:0] best,
	input  wire  [lbt_pkg::AREA_W-1:0] area,
	input  wire  [lbt_pkg::AREA_W-1:0] oldest,
	output lbt_pkg::cmp_res_t          res
);
	import lbt_pkg::*;

	logic [WORD_W-1:0] gap;

	assign gap = key - idx;

	// Strictly closer only, so the first of equal candidates is kept and the
	// widest possible distance can never be taken.
	always_comb begin
		res.gap      = gap;
		res.take     = (idx <= key) && (gap < best);
		res.area_hit = (area == oldest);
	end

endmodule

`default_nettype wire

>>> hdl/log_bookmark_table_core.sv
// ----------------------------------------------------------------------------
// Log bookmark table core
// Up to 32 bookmarks (area, offset, log index) with add, rotate, clear and
// closest-index query, one result per transaction.
// ----------------------------------------------------------------------------
// Add and clear strobe their result on done in the cycle after start is
// taken. Rotate and query walk the valid bookmarks through the single read
// port of the table memory at one slot per cycle, but a rotate halts the walk
// in S_MOVE and S_RD for each bookmark that it removes.
// busy is high for the whole walk. Every transaction gives exactly one result,
// shown for one cycle while done is high; the receiver cannot stall it, so it
// must take the result in that cycle. mark_count always shows the live count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module log_bookmark_table_core (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        capacity_we,
	input  wire  [lbt_pkg::CNT_W-1:0]  capacity_wdata,
	input  wire                        start,
	output logic                       busy,
	input  wire  [1:0]                 kind,
	input  wire  [lbt_pkg::AREA_W-1:0] entry_area,
	input  wire  [lbt_pkg::WORD_W-1:0] entry_offset,
	input  wire  [lbt_pkg::WORD_W-1:0] log_index,
	input  wire  [lbt_pkg::AREA_W-1:0] oldest_area,
	output logic                       done,
	output logic                       found,
	output logic [lbt_pkg::AREA_W-1:0] found_area,
	output logic [lbt_pkg::WORD_W-1:0] found_offset,
	output logic [lbt_pkg::WORD_W-1:0] found_index,
	output logic [lbt_pkg::CNT_W-1:0]  mark_count
);
	import lbt_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RD,
		S_CHK,
		S_MOVE
	} state_t;

	state_t            state_q;
	kind_t             kind_q;
	logic [CNT_W-1:0]  cap_q;
	logic [CNT_W-1:0]  vc_q;
	logic [ADDR_W-1:0] ws_q;
	logic [CNT_W-1:0]  i_q;
	logic [WORD_W-1:0] key_q;
	logic [AREA_W-1:0] oldest_q;
	logic [WORD_W-1:0] best_q;
	logic              done_q;
	logic              hit_q;
	logic [AREA_W-1:0] hit_area_q;
	logic [WORD_W-1:0] hit_offset_q;
	logic [WORD_W-1:0] hit_index_q;

	logic              accept;
	logic [CNT_W-1:0]  i_inc;
	logic [CNT_W-1:0]  last;
	logic [CNT_W-1:0]  ws_inc;
	logic [ADDR_W-1:0] ws_wrap;
	logic              advance;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	mark_t             wr_data;
	mark_t             rd_data;
	cmp_res_t          cmp_res;

	lbt_mem u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	lbt_cmp u_cmp (
		.key    (key_q),
		.idx    (rd_data.index),
		.best   (best_q),
		.area   (rd_data.area),
		.oldest (oldest_q),
		.res    (cmp_res)
	);

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	assign i_inc   = i_q + CNT_W'(1);
	assign last    = vc_q - CNT_W'(1);
	assign ws_inc  = {1'b0, ws_q} + CNT_W'(1);
	assign ws_wrap = (ws_inc >= cap_q) ? '0 : ws_inc[ADDR_W-1:0];
	assign advance = (kind_q == KIND_QUERY) || !cmp_res.area_hit;

	// The next slot is read while the current one is checked, so a scan moves
	// one slot per cycle until a rotate finds a bookmark to remove.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = i_q[ADDR_W-1:0];
		unique case (state_q)
			S_RD: begin
				rd_en = (i_q < vc_q);
			end
			S_CHK: begin
				if (advance) begin
					rd_en   = (i_inc < vc_q);
					rd_addr = i_inc[ADDR_W-1:0];
				end else if (i_q != last) begin
					rd_en   = 1'b1;
					rd_addr = last[ADDR_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		wr_en          = 1'b0;
		wr_addr        = ws_q;
		wr_data.area   = entry_area;
		wr_data.offset = entry_offset;
		wr_data.index  = log_index;
		if (state_q == S_MOVE) begin
			wr_en   = 1'b1;
			wr_addr = i_q[ADDR_W-1:0];
			wr_data = rd_data;
		end else if (accept && (kind_t'(kind) == KIND_ADD) && (cap_q != '0)) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			kind_q       <= KIND_ADD;
			cap_q        <= CNT_W'(MAX_MARKS);
			vc_q         <= '0;
			ws_q         <= '0;
			i_q          <= '0;
			key_q        <= '0;
			oldest_q     <= '0;
			best_q       <= WORD_ONES;
			done_q       <= 1'b0;
			hit_q        <= 1'b0;
			hit_area_q   <= '0;
			hit_offset_q <= '0;
			hit_index_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						kind_q       <= kind_t'(kind);
						key_q        <= log_index;
						oldest_q     <= oldest_area;
						best_q       <= WORD_ONES;
						i_q          <= '0;
						hit_q        <= 1'b0;
						hit_area_q   <= '0;
						hit_offset_q <= '0;
						hit_index_q  <= '0;
						unique case (kind_t'(kind))
							KIND_ADD: begin
								if (cap_q != '0) begin
									if (vc_q < cap_q) begin
										vc_q <= vc_q + CNT_W'(1);
									end
									ws_q <= ws_wrap;
								end
								done_q <= 1'b1;
							end
							KIND_CLEAR: begin
								vc_q   <= '0;
								ws_q   <= '0;
								done_q <= 1'b1;
							end
							KIND_ROTATE, KIND_QUERY: begin
								state_q <= S_RD;
							end
						endcase
					end
				end
				S_RD: begin
					if (i_q < vc_q) begin
						state_q <= S_CHK;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_CHK: begin
					if (advance) begin
						if ((kind_q == KIND_QUERY) && cmp_res.take) begin
							best_q       <= cmp_res.gap;
							hit_q        <= 1'b1;
							hit_area_q   <= rd_data.area;
							hit_offset_q <= rd_data.offset;
							hit_index_q  <= rd_data.index;
						end
						i_q <= i_inc;
						if (!(i_inc < vc_q)) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					end else if (i_q != last) begin
						state_q <= S_MOVE;
					end else begin
						// The match is the last bookmark: drop it and stop.
						vc_q    <= last;
						ws_q    <= last[ADDR_W-1:0];
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_MOVE: begin
					// The last bookmark lands in this slot, which is checked again.
					vc_q    <= last;
					ws_q    <= last[ADDR_W-1:0];
					state_q <= S_RD;
				end
			endcase
			if (capacity_we) begin
				cap_q <= (capacity_wdata > CNT_W'(MAX_MARKS)) ? CNT_W'(MAX_MARKS)
				                                              : capacity_wdata;
				vc_q  <= '0;
				ws_q  <= '0;
			end
		end
	end

	assign done         = done_q;
	assign found        = hit_q;
	assign found_area   = hit_area_q;
	assign found_offset = hit_offset_q;
	assign found_index  = hit_index_q;
	assign mark_count   = vc_q;

	a_count_in_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(vc_q <= cap_q) && (cap_q <= CNT_W'(MAX_MARKS)))
		else $error("bookmark count exceeds capacity");

	a_slot_in_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(ws_q == '0) || ({1'b0, ws_q} < cap_q))
		else $error("write slot outside capacity");

	a_done_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start)))
		else $error("result without a transaction");

	a_short_kinds: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && ((kind_t'(kind) == KIND_ADD) || (kind_t'(kind) == KIND_CLEAR)))
		|=> (done && !busy))
		else $error("add or clear did not finish in one cycle");

	a_move_rescans: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MOVE) |=> ((state_q == S_RD) && (vc_q == $past(vc_q) - CNT_W'(1))))
		else $error("rotate move did not shrink the table");

endmodule

`default_nettype wire
